// ===== sv/fsse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fsse_pkg
// Shared types and defaults for the frequency-sorted symbol emitter.
// ============================================================================
package fsse_pkg;

   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 256;
   localparam int SYM_PORT_W   = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD_WR,
      ST_SCAN,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } hist_ctl_type;

endpackage
`default_nettype wire

// ===== sv/frequency_sorted_symbol_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// frequency_sorted_symbol_emitter
// Counts loaded bytes in a histogram and drains them most-frequent first.
// ============================================================================
// A load transaction is a read-modify-write of its histogram bin. A read
// transaction that continues the current run is served in IDLE; a read that
// starts a new run first scans all bins through the single read port of the
// histogram memory (SCAN), then picks the run (PICK). Busy is high while a
// transaction is in progress. Each result appears in the cycle after its work
// ends and is shown for one cycle under rsp_strobe; the receiver cannot stall
// it. The histogram is empty right after reset, with no clearing pass.
// ============================================================================
module frequency_sorted_symbol_emitter #(
   parameter int MAX_LEN  = fsse_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = fsse_pkg::ALPHABET_DEF,
   localparam int CNT_W   = $clog2(MAX_LEN + 1),
   localparam int SYM_W   = $clog2(ALPHABET)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_mode,
   input  wire logic [fsse_pkg::SYM_PORT_W-1:0] req_symbol,
   output logic                                 rsp_strobe,
   output logic      [fsse_pkg::SYM_PORT_W-1:0] rsp_out_symbol,
   output logic      [CNT_W-1:0]                rsp_symbol_count,
   output logic                                 rsp_last,
   output logic                                 rsp_empty_res,
   output logic                                 rsp_overflow
);

   localparam int SP_W = fsse_pkg::SYM_PORT_W;

   fsse_pkg::state_type    state_ff, state_in;
   fsse_pkg::hist_ctl_type hist_ctl;

   logic [SYM_W-1:0] rd_addr, wr_addr;
   logic [CNT_W-1:0] wr_data, rd_count;

   logic [CNT_W-1:0] symbols_left_ff, symbols_left_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic [CNT_W-1:0] cur_total_ff, cur_total_in;
   logic [SYM_W-1:0] cur_sym_ff, cur_sym_in;
   logic             overflow_ff, overflow_in;
   logic [SYM_W-1:0] load_sym_ff, load_sym_in;
   logic [SYM_W:0]   scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [SYM_W-1:0] best_sym_ff, best_sym_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [SP_W-1:0]  rsp_symbol_ff, rsp_symbol_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic accept, sym_ok, full, scan_done;

   assign accept    = start & ~busy;
   assign sym_ok    = {1'b0, req_symbol} < (SP_W + 1)'(ALPHABET);
   assign full      = symbols_left_ff >= CNT_W'(MAX_LEN);
   assign scan_done = scan_cnt_ff == (SYM_W + 1)'(ALPHABET);

   fsse_hist #(
      .DEPTH (ALPHABET),
      .SYM_W (SYM_W),
      .CNT_W (CNT_W)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hist_ctl),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_count (rd_count)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsse_pkg::ST_IDLE: begin
            if (accept && !req_mode && sym_ok && !full) begin
               state_in = fsse_pkg::ST_LOAD_WR;
            end else if (accept && req_mode && (symbols_left_ff != '0) &&
                         (remaining_ff == '0)) begin
               state_in = fsse_pkg::ST_SCAN;
            end
         end
         fsse_pkg::ST_LOAD_WR: state_in = fsse_pkg::ST_IDLE;
         fsse_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = fsse_pkg::ST_PICK;
            end
         end
         fsse_pkg::ST_PICK: state_in = fsse_pkg::ST_IDLE;
         default: state_in = fsse_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy         = state_ff != fsse_pkg::ST_IDLE;
      hist_ctl.wr  = state_ff == fsse_pkg::ST_LOAD_WR;
      hist_ctl.clr = (state_ff == fsse_pkg::ST_PICK) && (best_cnt_ff != '0);
      rd_addr      = (state_ff == fsse_pkg::ST_SCAN) ? scan_cnt_ff[SYM_W-1:0]
                                                     : req_symbol[SYM_W-1:0];
      wr_addr      = (state_ff == fsse_pkg::ST_PICK) ? best_sym_ff : load_sym_ff;
      wr_data      = rd_count + CNT_W'(1);
   end

   // datapath
   always_comb begin
      symbols_left_in = symbols_left_ff;
      remaining_in    = remaining_ff;
      cur_total_in    = cur_total_ff;
      cur_sym_in      = cur_sym_ff;
      overflow_in     = overflow_ff;
      load_sym_in     = load_sym_ff;
      scan_cnt_in     = scan_cnt_ff;
      best_cnt_in     = best_cnt_ff;
      best_sym_in     = best_sym_ff;
      rsp_strobe_in   = 1'b0;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      unique case (state_ff)
         fsse_pkg::ST_IDLE: begin
            if (accept && !req_mode) begin
               load_sym_in = req_symbol[SYM_W-1:0];
               if (sym_ok && full) begin
                  overflow_in = 1'b1;
               end else if (sym_ok) begin
                  symbols_left_in = symbols_left_ff + CNT_W'(1);
               end
            end else if (accept && req_mode) begin
               if (symbols_left_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_symbol_in = '0;
                  rsp_count_in  = '0;
                  rsp_last_in   = 1'b0;
                  rsp_empty_in  = 1'b1;
                  rsp_ovf_in    = overflow_ff;
               end else if (remaining_ff != '0) begin
                  remaining_in    = remaining_ff - CNT_W'(1);
                  symbols_left_in = symbols_left_ff - CNT_W'(1);
                  rsp_strobe_in   = 1'b1;
                  rsp_symbol_in   = SP_W'(cur_sym_ff);
                  rsp_count_in    = cur_total_ff;
                  rsp_last_in     = symbols_left_ff == CNT_W'(1);
                  rsp_empty_in    = 1'b0;
                  rsp_ovf_in      = overflow_ff;
               end else begin
                  scan_cnt_in = '0;
                  best_cnt_in = '0;
                  best_sym_in = '0;
               end
            end
         end
         fsse_pkg::ST_LOAD_WR: begin
         end
         fsse_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + (SYM_W + 1)'(1);
            // registered read: rd_count belongs to the previous scan address
            if ((scan_cnt_ff != '0) && (rd_count > best_cnt_ff)) begin
               best_cnt_in = rd_count;
               best_sym_in = SYM_W'(scan_cnt_ff - (SYM_W + 1)'(1));
            end
         end
         fsse_pkg::ST_PICK: begin
            rsp_strobe_in = 1'b1;
            rsp_ovf_in    = overflow_ff;
            if (best_cnt_ff == '0) begin
               symbols_left_in = '0;
               rsp_symbol_in   = '0;
               rsp_count_in    = '0;
               rsp_last_in     = 1'b0;
               rsp_empty_in    = 1'b1;
            end else begin
               cur_sym_in      = best_sym_ff;
               cur_total_in    = best_cnt_ff;
               remaining_in    = best_cnt_ff - CNT_W'(1);
               symbols_left_in = symbols_left_ff - CNT_W'(1);
               rsp_symbol_in   = SP_W'(best_sym_ff);
               rsp_count_in    = best_cnt_ff;
               rsp_last_in     = symbols_left_ff == CNT_W'(1);
               rsp_empty_in    = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fsse_pkg::ST_IDLE;
         symbols_left_ff <= '0;
         remaining_ff    <= '0;
         cur_total_ff    <= '0;
         cur_sym_ff      <= '0;
         overflow_ff     <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         symbols_left_ff <= symbols_left_in;
         remaining_ff    <= remaining_in;
         cur_total_ff    <= cur_total_in;
         cur_sym_ff      <= cur_sym_in;
         overflow_ff     <= overflow_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      load_sym_ff   <= load_sym_in;
      scan_cnt_ff   <= scan_cnt_in;
      best_cnt_ff   <= best_cnt_in;
      best_sym_ff   <= best_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_symbol   = rsp_symbol_ff;
   assign rsp_symbol_count = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_empty_res    = rsp_empty_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(accept && req_mode) ||
                      ($past(state_ff) == fsse_pkg::ST_PICK)))
      else $error("result without a read transaction");

   a_last_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> (symbols_left_ff == '0))
      else $error("last flagged with symbols left");

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      symbols_left_ff <= CNT_W'(MAX_LEN))
      else $error("symbol count above maximum length");

   a_run_within_left: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= symbols_left_ff)
      else $error("current run exceeds symbols left");

endmodule
`default_nettype wire

// ===== sv/fsse_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fsse_hist
// Histogram store: one-port-read, one-port-write bin memory with a valid bit
// per bin; an invalid bin reads as zero.
// ============================================================================
module fsse_hist #(
   parameter int DEPTH = fsse_pkg::ALPHABET_DEF,
   parameter int SYM_W = 8,
   parameter int CNT_W = 13
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fsse_pkg::hist_ctl_type ctl,
   input  wire logic [SYM_W-1:0]     rd_addr,
   input  wire logic [SYM_W-1:0]     wr_addr,
   input  wire logic [CNT_W-1:0]     wr_data,
   output logic      [CNT_W-1:0]     rd_count
);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0] rd_data_ff;
   logic             valid_rd_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (ctl.wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         valid_rd_ff <= 1'b0;
      end else begin
         valid_rd_ff <= valid_ff[rd_addr];
         if (ctl.wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (ctl.clr) begin
            valid_ff[wr_addr] <= 1'b0;
         end
      end
   end

   assign rd_count = valid_rd_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== bench/fsse_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsse_tb_pkg
// Command codes shared by the emitter testbench and its checker.
// ============================================================================
package fsse_tb_pkg;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

endpackage

// ===== bench/fsse_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fsse_checker
// Watches the command and result channels of the frequency-sorted symbol
// emitter. Keeps its own histogram, picks runs by highest count (lowest code
// on a tie) and compares every result strobe, field by field, with the
// oldest predicted emit.
// ============================================================================
module fsse_checker #(
   parameter int MAX_LEN  = fsse_pkg::MAX_LEN_DEF,
   parameter int ALPHABET = fsse_pkg::ALPHABET_DEF,
   localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic                            req_mode,
   input  wire logic [fsse_pkg::SYM_PORT_W-1:0] req_symbol,
   input  wire logic                            rsp_strobe,
   input  wire logic [fsse_pkg::SYM_PORT_W-1:0] rsp_out_symbol,
   input  wire logic [CNT_W-1:0]                rsp_symbol_count,
   input  wire logic                            rsp_last,
   input  wire logic                            rsp_empty_res,
   input  wire logic                            rsp_overflow,
   output int                                   mismatches,
   output int                                   outstanding
);

   typedef struct packed {
      logic [fsse_pkg::SYM_PORT_W-1:0] symbol;
      logic [CNT_W-1:0]                count;
      logic                            last;
      logic                            empty;
      logic                            ovf;
   } emit_type;

   emit_type pending_emits[$];

   int   bin_count [ALPHABET];
   int   run_symbol;
   int   run_total;
   int   run_left;
   int   stored_total;
   logic drop_flag;

   initial mismatches = 0;

   task automatic clear_histogram();
      foreach (bin_count[i]) bin_count[i] = 0;
      run_symbol   = 0;
      run_total    = 0;
      run_left     = 0;
      stored_total = 0;
      drop_flag    = 1'b0;
   endtask

   task automatic apply_transaction(input logic mode, input int sym);
      emit_type e;
      int       best_sym;
      int       best_cnt;
      e = '0;
      if (mode == fsse_tb_pkg::MODE_LOAD) begin
         if (sym < ALPHABET) begin
            if (stored_total >= MAX_LEN) begin
               drop_flag = 1'b1;
            end else begin
               bin_count[sym]++;
               stored_total++;
            end
         end
      end else begin
         e.ovf = drop_flag;
         if (stored_total != 0 && run_left == 0) begin
            best_sym = 0;
            best_cnt = 0;
            for (int i = 0; i < ALPHABET; i++) begin
               if (bin_count[i] > best_cnt) begin
                  best_cnt = bin_count[i];
                  best_sym = i;
               end
            end
            run_symbol = best_sym;
            run_total  = best_cnt;
            run_left   = best_cnt;
            bin_count[best_sym] = 0;
         end
         if (stored_total == 0 || run_left == 0) begin
            stored_total = 0;
            e.empty      = 1'b1;
         end else begin
            run_left--;
            stored_total--;
            e.symbol = run_symbol[fsse_pkg::SYM_PORT_W-1:0];
            e.count  = run_total[CNT_W-1:0];
            e.last   = (stored_total == 0);
         end
         pending_emits.insert(pending_emits.size(), e);
      end
   endtask

   task automatic note_mismatch(input string what, input emit_type want);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: emit mismatch (%s)", $realtime, what);
         $display("   expected sym %h cnt %0d last %b empty %b ovf %b",
                  want.symbol, want.count, want.last, want.empty, want.ovf);
         $display("   actual   sym %h cnt %0d last %b empty %b ovf %b",
                  rsp_out_symbol, rsp_symbol_count, rsp_last, rsp_empty_res,
                  rsp_overflow);
      end
   endtask

   task automatic check_emit();
      emit_type want;
      string    bad;
      bad = "";
      if (pending_emits.size() == 0) begin
         note_mismatch("no transaction waiting", '0);
      end else begin
         want = pending_emits.pop_front();
         if (rsp_out_symbol !== want.symbol) bad = {bad, " out_symbol"};
         if (rsp_symbol_count !== want.count) bad = {bad, " symbol_count"};
         if (rsp_last !== want.last) bad = {bad, " last"};
         if (rsp_empty_res !== want.empty) bad = {bad, " empty_res"};
         if (rsp_overflow !== want.ovf) bad = {bad, " overflow"};
         if (bad != "") note_mismatch(bad, want);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_histogram();
         pending_emits.delete();
      end else begin
         if (rsp_strobe !== 1'b0) check_emit();
         if (start === 1'b1 && busy === 1'b0)
            apply_transaction(req_mode, int'(req_symbol));
      end
      outstanding <= pending_emits.size();
   end

endmodule

// ===== bench/tb_frequency_sorted_symbol_emitter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_frequency_sorted_symbol_emitter
// Drives load and read transactions into the emitter: directed cases (empty
// reads, ties, loads during a drain) and random load/drain sequences with
// noise. The checker beside the block predicts and compares; this top gives
// the verdict.
// ============================================================================
module tb_frequency_sorted_symbol_emitter;

   localparam int MAX_LEN     = fsse_pkg::MAX_LEN_DEF;
   localparam int CNT_W       = $clog2(MAX_LEN + 1);
   localparam int ITEM_TARGET = 1800;
   localparam int IDLE_LIMIT  = 4000;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            start      = 1'b0;
   logic                            req_mode   = 1'b0;
   logic [fsse_pkg::SYM_PORT_W-1:0] req_symbol = '0;
   logic                            busy;
   logic                            rsp_strobe;
   logic [fsse_pkg::SYM_PORT_W-1:0] rsp_out_symbol;
   logic [CNT_W-1:0]                rsp_symbol_count;
   logic                            rsp_last;
   logic                            rsp_empty_res;
   logic                            rsp_overflow;
   int                              mismatches;
   int                              outstanding;

   int         stored      = 0;
   int         sent        = 0;
   int         idle_cycles = 0;
   bit         no_gap      = 1'b0;
   int         pool_size   = 1;
   logic [7:0] sym_pool [8];

   frequency_sorted_symbol_emitter dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_symbol       (req_symbol),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_symbol_count (rsp_symbol_count),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow)
   );

   fsse_checker emit_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_symbol       (req_symbol),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_symbol_count (rsp_symbol_count),
      .rsp_last         (rsp_last),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(input fsse_tb_pkg::mode_type mode, input logic [7:0] sym);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_mode   <= mode;
      req_symbol <= sym;
      do @(posedge clock); while (busy !== 1'b0);
      if (mode == fsse_tb_pkg::MODE_LOAD) begin
         if (stored < MAX_LEN) stored++;
      end else if (stored != 0) begin
         stored--;
      end
      sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] pool_symbol();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return sym_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   // reads until the store is empty, with the odd load slipped in mid-drain
   task automatic drain_store();
      while (stored != 0) begin
         if ($urandom_range(0, 9) == 0)
            send_item(fsse_tb_pkg::MODE_LOAD, pool_symbol());
         else
            send_item(fsse_tb_pkg::MODE_READ, 8'($urandom));
      end
   endtask

   initial begin
      int kind;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty read, extremes of symbol, tie on counts, same-symbol load mid-run
      send_item(fsse_tb_pkg::MODE_READ, 8'hFF);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'hFF);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h00);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'hFF);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h00);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h07);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h55);
      send_item(fsse_tb_pkg::MODE_READ, 8'hAA);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h80);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_LOAD, 8'h01);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);
      wait_drained();

      while (sent < ITEM_TARGET) begin
         no_gap    = ($urandom_range(0, 3) == 0);
         kind      = $urandom_range(0, 9);
         pool_size = $urandom_range(1, 8);
         foreach (sym_pool[i]) sym_pool[i] = 8'($urandom);
         if (kind < 7) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                            : $urandom_range(1, 24);
            repeat (n) send_item(fsse_tb_pkg::MODE_LOAD, pool_symbol());
            if (kind == 6) begin
               repeat ($urandom_range(1, n))
                  send_item(fsse_tb_pkg::MODE_READ, 8'($urandom));
            end else begin
               drain_store();
               repeat ($urandom_range(0, 2))
                  send_item(fsse_tb_pkg::MODE_READ, 8'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 20))
               send_item(fsse_tb_pkg::mode_type'($urandom_range(0, 1)), 8'($urandom));
         end
         if ($urandom_range(0, 4) == 0) wait_drained();
      end
      no_gap = 1'b0;
      drain_store();
      send_item(fsse_tb_pkg::MODE_READ, 8'h00);

      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
